[sv/vcf_pkg.sv]
// vcf_pkg: shared widths, register map, micro-op codes, microcode rom and
// saturating arithmetic helpers for the vertical complementary fusion block
// no dependencies
package vcf_pkg;

  localparam int DATA_W            = 32;
  localparam int DT_W              = 16;
  localparam int WARM_W            = 10;
  localparam int TAP_W             = 3;
  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int OPND_W            = 34;  // widest multiplier operand (2*v + dv)
  localparam int MULB_W            = 33;  // unsigned 32-bit gain as signed
  localparam int PROD_W            = OPND_W + MULB_W;
  localparam int CFG_AW            = 5;
  localparam int CFG_DW            = 32;
  localparam int UC_AW             = 5;

  localparam logic [WARM_W-1:0] WARMUP_RST   = 10'd500;
  localparam logic [DATA_W-1:0] GAIN_ACC_RST = 32'd2427;
  localparam logic [DATA_W-1:0] GAIN_VEL_RST = 32'd21845;
  localparam logic [DATA_W-1:0] GAIN_POS_RST = 32'd65536;
  localparam logic [TAP_W-1:0]  TAP_RST      = 3'd2;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_WARMUP   = 3'd0,
    REG_GAIN_ACC = 3'd1,
    REG_GAIN_VEL = 3'd2,
    REG_GAIN_POS = 3'd3,
    REG_TAP      = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MA_ERR  = 2'd0,
    MA_TMP  = 2'd1,
    MA_OPND = 2'd2
  } mul_a_t;

  typedef enum logic [1:0] {
    MB_GA = 2'd0,
    MB_GV = 2'd1,
    MB_GP = 2'd2,
    MB_DT = 2'd3
  } mul_b_t;

  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_ERR   = 4'd1,
    OP_ACORR = 4'd2,
    OP_VCORR = 4'd3,
    OP_PCORR = 4'd4,
    OP_CA    = 4'd5,
    OP_DVSUM = 4'd6,
    OP_DV    = 4'd7,
    OP_FVEL  = 4'd8,
    OP_RPOS  = 4'd9,
    OP_POS   = 4'd10
  } alu_op_t;

  typedef enum logic [1:0] {
    SQ_NEXT    = 2'd0,
    SQ_BR_WARM = 2'd1,
    SQ_DONE    = 2'd2
  } seq_op_t;

  typedef struct packed {
    logic             mul_en;
    mul_a_t           mul_a;
    mul_b_t           mul_b;
    logic             rnd_en;
    logic             rnd17;
    alu_op_t          op;
    seq_op_t          sq;
    logic [UC_AW-1:0] tgt;
  } ctl_t;

  localparam logic [UC_AW-1:0] UC_SKIP = 5'd16;

  function automatic ctl_t mk(input logic mul_en, input mul_a_t a, input mul_b_t b,
                              input logic rnd_en, input logic rnd17, input alu_op_t op,
                              input seq_op_t sq, input logic [UC_AW-1:0] tgt);
    ctl_t w;
    w.mul_en = mul_en;
    w.mul_a  = a;
    w.mul_b  = b;
    w.rnd_en = rnd_en;
    w.rnd17  = rnd17;
    w.op     = op;
    w.sq     = sq;
    w.tgt    = tgt;
    return w;
  endfunction

  // microcode: multiply, round/saturate and the state update unit overlap
  function automatic ctl_t ucode(input logic [UC_AW-1:0] step);
    ctl_t w;
    case (step)
      5'd0:    w = mk(1'b0, MA_ERR,  MB_GA, 1'b0, 1'b0, OP_ERR,   SQ_BR_WARM, UC_SKIP);
      5'd1:    w = mk(1'b1, MA_ERR,  MB_GA, 1'b0, 1'b0, OP_NONE,  SQ_NEXT, '0);
      5'd2:    w = mk(1'b0, MA_ERR,  MB_GA, 1'b1, 1'b0, OP_NONE,  SQ_NEXT, '0);
      5'd3:    w = mk(1'b1, MA_TMP,  MB_DT, 1'b0, 1'b0, OP_NONE,  SQ_NEXT, '0);
      5'd4:    w = mk(1'b0, MA_ERR,  MB_GA, 1'b1, 1'b0, OP_NONE,  SQ_NEXT, '0);
      5'd5:    w = mk(1'b1, MA_ERR,  MB_GV, 1'b0, 1'b0, OP_ACORR, SQ_NEXT, '0);
      5'd6:    w = mk(1'b0, MA_ERR,  MB_GA, 1'b1, 1'b0, OP_CA,    SQ_NEXT, '0);
      5'd7:    w = mk(1'b1, MA_TMP,  MB_DT, 1'b0, 1'b0, OP_DVSUM, SQ_NEXT, '0);
      5'd8:    w = mk(1'b1, MA_OPND, MB_DT, 1'b1, 1'b0, OP_NONE,  SQ_NEXT, '0);
      5'd9:    w = mk(1'b1, MA_ERR,  MB_GP, 1'b1, 1'b1, OP_VCORR, SQ_NEXT, '0);
      5'd10:   w = mk(1'b0, MA_ERR,  MB_GA, 1'b1, 1'b0, OP_DV,    SQ_NEXT, '0);
      5'd11:   w = mk(1'b1, MA_TMP,  MB_DT, 1'b0, 1'b0, OP_FVEL,  SQ_NEXT, '0);
      5'd12:   w = mk(1'b1, MA_OPND, MB_DT, 1'b1, 1'b0, OP_NONE,  SQ_NEXT, '0);
      5'd13:   w = mk(1'b0, MA_ERR,  MB_GA, 1'b1, 1'b1, OP_PCORR, SQ_NEXT, '0);
      5'd14:   w = mk(1'b0, MA_ERR,  MB_GA, 1'b0, 1'b0, OP_RPOS,  SQ_NEXT, '0);
      5'd15:   w = mk(1'b0, MA_ERR,  MB_GA, 1'b0, 1'b0, OP_POS,   SQ_DONE, '0);
      5'd16:   w = mk(1'b0, MA_ERR,  MB_GA, 1'b0, 1'b0, OP_NONE,  SQ_DONE, '0);
      default: w = mk(1'b0, MA_ERR,  MB_GA, 1'b0, 1'b0, OP_NONE,  SQ_DONE, '0);
    endcase
    return w;
  endfunction

  // saturating 32-bit add or subtract
  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b,
                                                       input logic sub);
    logic [DATA_W:0] s;
    s = sub ? ({a[DATA_W-1], a} - {b[DATA_W-1], b}) : ({a[DATA_W-1], a} + {b[DATA_W-1], b});
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? SAT_MIN : SAT_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [PROD_W-1:0] x);
    if (x[PROD_W-1:DATA_W-1] == {(PROD_W-DATA_W+1){x[PROD_W-1]}}) begin
      return x[DATA_W-1:0];
    end
    return x[PROD_W-1] ? SAT_MIN : SAT_MAX;
  endfunction

  // round half up, arithmetic shift by 16 or 17, saturate
  function automatic logic signed [DATA_W-1:0] rnd_sat(input logic signed [PROD_W-1:0] p,
                                                       input logic s17);
    logic signed [PROD_W-1:0] half;
    logic signed [PROD_W-1:0] y;
    half = '0;
    if (s17) begin
      half[16] = 1'b1;
    end else begin
      half[15] = 1'b1;
    end
    y = p + half;
    y = s17 ? (y >>> 17) : (y >>> 16);
    return sat_wide(y);
  endfunction

endpackage

[sv/vcf_if.sv]
// vcf_if: valid/ready stream interfaces for the input and result channels
// depends on vcf_pkg for field widths
interface vcf_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [vcf_pkg::DATA_W-1:0]  baro_height;
  logic signed [vcf_pkg::DATA_W-1:0]  accel_z;
  logic        [vcf_pkg::DT_W-1:0]    time_step;

  modport source (output valid, output baro_height, output accel_z, output time_step,
                  input ready);
  modport sink   (input valid, input baro_height, input accel_z, input time_step,
                  output ready);
endinterface

interface vcf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [vcf_pkg::DATA_W-1:0]  fused_height;
  logic signed [vcf_pkg::DATA_W-1:0]  fused_velocity;
  logic signed [vcf_pkg::DATA_W-1:0]  fused_accel;
  logic                               fusion_active;

  modport source (output valid, output fused_height, output fused_velocity,
                  output fused_accel, output fusion_active, input ready);
  modport sink   (input valid, input fused_height, input fused_velocity,
                  input fused_accel, input fusion_active, output ready);
endinterface

[sv/vcf_useq.sv]
// vcf_useq: step counter and microcode rom sequencer for the fusion datapath
// depends on vcf_pkg (ctl_t, ucode)
module vcf_useq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          warm,
  output vcf_pkg::ctl_t ctl,
  output logic          busy,
  output logic          done
);

  logic [vcf_pkg::UC_AW-1:0] pc_r;
  logic [vcf_pkg::UC_AW-1:0] pc_nxt;
  logic                      busy_r;
  logic                      busy_nxt;
  vcf_pkg::ctl_t             word;

  assign word = vcf_pkg::ucode(pc_r);

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (busy_r) begin
      case (word.sq)
        vcf_pkg::SQ_NEXT:    pc_nxt = pc_r + 1'b1;
        vcf_pkg::SQ_BR_WARM: pc_nxt = warm ? word.tgt : pc_r + 1'b1;
        vcf_pkg::SQ_DONE:    busy_nxt = 1'b0;
        default:             busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign ctl  = busy_r ? word : '0;
  assign busy = busy_r;
  assign done = busy_r && (word.sq == vcf_pkg::SQ_DONE);

endmodule

[sv/vertical_complementary_fusion.sv]
// vertical_complementary_fusion: third-order complementary altitude filter
// depends on vcf_pkg, vcf_if (vcf_in_if, vcf_out_if) and vcf_useq
//
// usage
//   in_ch  : valid/ready channel, one transaction per sample (barometer height,
//            vertical acceleration, Q0.16 time step)
//   out_ch : valid/ready channel, one transaction per accepted sample
//   cfg_*  : apb-style register port, registers at byte offsets 0,4,8,12,16
//            (warm-up count, three gains, delay tap); pready is tied high,
//            write only while the block is idle
// sequence
//   a fusing sample is accepted, then runs a 16-step microprogram that shares
//   one 34x33 multiplier and one round/saturate stage, then waits in the hold
//   state until the output slot is free; a warm-up sample branches from step
//   0 to the final step; the next sample is taken once a result is handed on
// reset
//   synchronous active-low; clears filter state, history and the warm-up
//   counter, and loads the register defaults
// stalls
//   the result sits in an output register; the next sample may be accepted
//   and processed while it waits, and its own result waits for the slot
module vertical_complementary_fusion #(
  parameter int HISTORY_DEPTH = vcf_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  vcf_in_if.sink                      in_ch,
  vcf_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [vcf_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [vcf_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [vcf_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int DW = vcf_pkg::DATA_W;
  // the tap never reaches past entry 2**TAP_W-1, so deeper history is never read
  localparam int TAP_SPAN = 2 ** vcf_pkg::TAP_W;
  localparam int HIST_N   = (HISTORY_DEPTH < TAP_SPAN) ? HISTORY_DEPTH : TAP_SPAN;
  localparam int HIST_IW  = $clog2(HIST_N);
  localparam logic [vcf_pkg::TAP_W:0] HIST_N_C = (vcf_pkg::TAP_W + 1)'(HIST_N);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [vcf_pkg::WARM_W-1:0] warmup_r;
  logic [DW-1:0]              gain_acc_r;
  logic [DW-1:0]              gain_vel_r;
  logic [DW-1:0]              gain_pos_r;
  logic [vcf_pkg::TAP_W-1:0]  tap_r;
  logic                       cfg_wr;
  vcf_pkg::cfg_reg_t          cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = vcf_pkg::cfg_reg_t'(cfg_paddr[vcf_pkg::CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warmup_r   <= vcf_pkg::WARMUP_RST;
      gain_acc_r <= vcf_pkg::GAIN_ACC_RST;
      gain_vel_r <= vcf_pkg::GAIN_VEL_RST;
      gain_pos_r <= vcf_pkg::GAIN_POS_RST;
      tap_r      <= vcf_pkg::TAP_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        vcf_pkg::REG_WARMUP:   warmup_r   <= cfg_pwdata[vcf_pkg::WARM_W-1:0];
        vcf_pkg::REG_GAIN_ACC: gain_acc_r <= cfg_pwdata[DW-1:0];
        vcf_pkg::REG_GAIN_VEL: gain_vel_r <= cfg_pwdata[DW-1:0];
        vcf_pkg::REG_GAIN_POS: gain_pos_r <= cfg_pwdata[DW-1:0];
        vcf_pkg::REG_TAP:      tap_r      <= cfg_pwdata[vcf_pkg::TAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      vcf_pkg::REG_WARMUP:
        cfg_prdata = {{(vcf_pkg::CFG_DW-vcf_pkg::WARM_W){1'b0}}, warmup_r};
      vcf_pkg::REG_GAIN_ACC: cfg_prdata = gain_acc_r;
      vcf_pkg::REG_GAIN_VEL: cfg_prdata = gain_vel_r;
      vcf_pkg::REG_GAIN_POS: cfg_prdata = gain_pos_r;
      vcf_pkg::REG_TAP:
        cfg_prdata = {{(vcf_pkg::CFG_DW-vcf_pkg::TAP_W){1'b0}}, tap_r};
      default:               cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // control: accept, run the microprogram, hand the result to the output slot
  // ---------------------------------------------------------------------------
  state_t                     state_r;
  state_t                     state_nxt;
  logic                       in_acc;
  logic                       out_load;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic                       warm_r;
  logic                       warm_nxt;
  logic [vcf_pkg::WARM_W-1:0] wcnt_r;
  logic [vcf_pkg::WARM_W-1:0] wcnt_nxt;
  vcf_pkg::ctl_t              ctl;
  logic                       seq_busy;
  logic                       seq_done;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  // result leaves the hold state once the output slot is empty or emptying
  assign out_load    = (state_r == S_HOLD) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    wcnt_nxt      = wcnt_r;
    warm_nxt      = warm_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (wcnt_r < warmup_r) begin
            wcnt_nxt = wcnt_r + 1'b1;
          end
          // the sample that reaches the count already fuses
          warm_nxt  = (wcnt_nxt < warmup_r);
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (seq_done) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wcnt_r      <= '0;
      warm_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wcnt_r      <= wcnt_nxt;
      warm_r      <= warm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  vcf_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .warm  (warm_nxt),
    .ctl   (ctl),
    .busy  (seq_busy),
    .done  (seq_done)
  );

  // ---------------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------------
  // sample holding registers
  logic signed [DW-1:0]           baro_r;
  logic signed [DW-1:0]           accz_r;
  logic [vcf_pkg::DT_W-1:0]       dt_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      baro_r <= in_ch.baro_height;
      accz_r <= in_ch.accel_z;
      dt_r   <= in_ch.time_step;
    end
  end

  // filter state
  logic signed [DW-1:0] acorr_r, acorr_nxt;
  logic signed [DW-1:0] vcorr_r, vcorr_nxt;
  logic signed [DW-1:0] pcorr_r, pcorr_nxt;
  logic signed [DW-1:0] ca_r,    ca_nxt;
  logic signed [DW-1:0] rvel_r,  rvel_nxt;
  logic signed [DW-1:0] rpos_r,  rpos_nxt;
  logic signed [DW-1:0] fvel_r,  fvel_nxt;
  logic signed [DW-1:0] hist_r   [HIST_N];
  logic signed [DW-1:0] hist_nxt [HIST_N];

  // scratch: height error, rounded value, multiplier operand and product
  logic signed [DW-1:0]                  err_r,  err_nxt;
  logic signed [DW-1:0]                  tmp_r;
  logic signed [vcf_pkg::OPND_W-1:0]     opnd_r, opnd_nxt;
  logic signed [vcf_pkg::PROD_W-1:0]     prod_r;
  logic signed [vcf_pkg::OPND_W-1:0]     mul_a;
  logic signed [vcf_pkg::MULB_W-1:0]     mul_b;
  logic [vcf_pkg::TAP_W:0]               tap_c;
  logic [HIST_IW-1:0]                    tap_idx;

  // tap beyond the stored history reads the oldest entry
  assign tap_c   = ({1'b0, tap_r} >= HIST_N_C) ? (HIST_N_C - 1'b1) : {1'b0, tap_r};
  assign tap_idx = tap_c[HIST_IW-1:0];

  always_comb begin
    case (ctl.mul_a)
      vcf_pkg::MA_ERR:  mul_a = {{(vcf_pkg::OPND_W-DW){err_r[DW-1]}}, err_r};
      vcf_pkg::MA_TMP:  mul_a = {{(vcf_pkg::OPND_W-DW){tmp_r[DW-1]}}, tmp_r};
      vcf_pkg::MA_OPND: mul_a = opnd_r;
      default:          mul_a = '0;
    endcase
    case (ctl.mul_b)
      vcf_pkg::MB_GA: mul_b = {{(vcf_pkg::MULB_W-DW){1'b0}}, gain_acc_r};
      vcf_pkg::MB_GV: mul_b = {{(vcf_pkg::MULB_W-DW){1'b0}}, gain_vel_r};
      vcf_pkg::MB_GP: mul_b = {{(vcf_pkg::MULB_W-DW){1'b0}}, gain_pos_r};
      vcf_pkg::MB_DT: mul_b = {{(vcf_pkg::MULB_W-vcf_pkg::DT_W){1'b0}}, dt_r};
      default:        mul_b = '0;
    endcase
  end

  // state update unit, one micro-op per step
  always_comb begin
    acorr_nxt = acorr_r;
    vcorr_nxt = vcorr_r;
    pcorr_nxt = pcorr_r;
    ca_nxt    = ca_r;
    rvel_nxt  = rvel_r;
    rpos_nxt  = rpos_r;
    fvel_nxt  = fvel_r;
    hist_nxt  = hist_r;
    err_nxt   = err_r;
    opnd_nxt  = opnd_r;
    case (ctl.op)
      vcf_pkg::OP_NONE: ;
      vcf_pkg::OP_ERR:   err_nxt   = vcf_pkg::sat_add(baro_r, hist_r[tap_idx], 1'b1);
      vcf_pkg::OP_ACORR: acorr_nxt = vcf_pkg::sat_add(acorr_r, tmp_r, 1'b0);
      vcf_pkg::OP_VCORR: vcorr_nxt = vcf_pkg::sat_add(vcorr_r, tmp_r, 1'b0);
      vcf_pkg::OP_PCORR: pcorr_nxt = vcf_pkg::sat_add(pcorr_r, tmp_r, 1'b0);
      vcf_pkg::OP_CA: begin
        ca_nxt   = vcf_pkg::sat_add(accz_r, acorr_r, 1'b0);
        // keep the previous corrected acceleration for the trapezoid
        opnd_nxt = {{(vcf_pkg::OPND_W-DW){ca_r[DW-1]}}, ca_r};
      end
      vcf_pkg::OP_DVSUM: begin
        opnd_nxt = opnd_r + {{(vcf_pkg::OPND_W-DW){ca_r[DW-1]}}, ca_r};
      end
      vcf_pkg::OP_DV: begin
        // tmp holds dv here; the position step uses the old fused velocity
        rvel_nxt = vcf_pkg::sat_add(rvel_r, tmp_r, 1'b0);
        opnd_nxt = {{(vcf_pkg::OPND_W-DW-1){fvel_r[DW-1]}}, fvel_r, 1'b0}
                 + {{(vcf_pkg::OPND_W-DW){tmp_r[DW-1]}}, tmp_r};
      end
      vcf_pkg::OP_FVEL:  fvel_nxt = vcf_pkg::sat_add(rvel_r, vcorr_r, 1'b0);
      vcf_pkg::OP_RPOS:  rpos_nxt = vcf_pkg::sat_add(rpos_r, tmp_r, 1'b0);
      vcf_pkg::OP_POS: begin
        for (int i = 1; i < HIST_N; i++) begin
          hist_nxt[i] = hist_r[i-1];
        end
        hist_nxt[0] = vcf_pkg::sat_add(rpos_r, pcorr_r, 1'b0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acorr_r <= '0;
      vcorr_r <= '0;
      pcorr_r <= '0;
      ca_r    <= '0;
      rvel_r  <= '0;
      rpos_r  <= '0;
      fvel_r  <= '0;
      for (int i = 0; i < HIST_N; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      acorr_r <= acorr_nxt;
      vcorr_r <= vcorr_nxt;
      pcorr_r <= pcorr_nxt;
      ca_r    <= ca_nxt;
      rvel_r  <= rvel_nxt;
      rpos_r  <= rpos_nxt;
      fvel_r  <= fvel_nxt;
      hist_r  <= hist_nxt;
    end
  end

  // shared multiplier and round/saturate stage, one register each
  always_ff @(posedge clk) begin
    err_r  <= err_nxt;
    opnd_r <= opnd_nxt;
    if (ctl.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (ctl.rnd_en) begin
      tmp_r <= vcf_pkg::rnd_sat(prod_r, ctl.rnd17);
    end
  end

  // ---------------------------------------------------------------------------
  // result register; the newest history entry is the fused height
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] out_h_r;
  logic signed [DW-1:0] out_v_r;
  logic signed [DW-1:0] out_a_r;
  logic                 out_act_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_h_r   <= warm_r ? '0 : hist_r[0];
      out_v_r   <= warm_r ? '0 : fvel_r;
      out_a_r   <= warm_r ? '0 : ca_r;
      out_act_r <= !warm_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.fused_height   = out_h_r;
  assign out_ch.fused_velocity = out_v_r;
  assign out_ch.fused_accel    = out_a_r;
  assign out_ch.fusion_active  = out_act_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) == seq_busy)
    else $error("sequencer activity out of step with control state");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> seq_busy)
    else $error("accepted transaction did not start the microprogram");

  a_wcnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(wcnt_r))
    else $error("warm-up counter moved without a transaction");

  a_warm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_act_r |-> (out_h_r == '0) && (out_v_r == '0) && (out_a_r == '0))
    else $error("warm-up result carries nonzero payload");

endmodule

[tb/tb_vertical_complementary_fusion.sv]
// self-checking testbench for vertical_complementary_fusion: a directed table
// then random phases, every result checked against an in-bench altitude filter
// depends on vcf_pkg, vcf_if and the vertical_complementary_fusion rtl
module tb_vertical_complementary_fusion;
  timeunit 1ns;
  timeprecision 1ps;

  import vcf_pkg::*;

  localparam int HIST_DEPTH    = HISTORY_DEPTH_DEF;
  localparam int NUM_REGS      = 5;
  localparam int LAST_SLOT     = 7;     // highest register index the address reaches
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 155;
  localparam int QUIET_LIMIT   = 3000;  // cycles with no transaction on either channel
  localparam int SETTLE_CYCLES = 24;    // margin waited after the final drain
  localparam int MAX_PRINTED   = 40;

  typedef logic signed [DATA_W-1:0] q16_t;
  typedef logic [DT_W-1:0]          dt_t;

  typedef struct {
    q16_t height;
    q16_t velocity;
    q16_t accel;
    logic active;
  } fusion_res_t;

  typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_t;

  // one row of the directed table: either a register write or a sample;
  // warm marks samples whose result is known to be the all-zero warm-up result
  typedef struct {
    row_kind_t         kind;
    int                reg_idx;
    logic [CFG_DW-1:0] wdata;
    q16_t              baro;
    q16_t              accel;
    dt_t               dt;
    bit                warm;
  } stim_row_t;

  localparam q16_t Q_MAX = SAT_MAX;
  localparam q16_t Q_MIN = SAT_MIN;
  localparam dt_t  DT_MAX = '1;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  vcf_in_if  in_ch ();
  vcf_out_if out_ch ();

  vertical_complementary_fusion DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // register shadow
  logic [WARM_W-1:0] warmup_len;
  logic [DATA_W-1:0] k_acc;
  logic [DATA_W-1:0] k_vel;
  logic [DATA_W-1:0] k_pos;
  logic [TAP_W-1:0]  tap_sel;

  // filter state of the in-bench altitude filter
  logic [WARM_W-1:0] warm_count;
  q16_t              acc_corr;
  q16_t              vel_corr;
  q16_t              pos_corr;
  q16_t              accel_est;
  q16_t              raw_vel;
  q16_t              raw_pos;
  q16_t              vel_est;
  q16_t              height_hist [HIST_DEPTH];

  fusion_res_t pending_results [$];
  int          error_count;
  int          quiet_cycles;
  bit          idling;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // fixed-point helpers
  // ---------------------------------------------------------------------------

  // clamp to the signed 32-bit range
  function automatic q16_t clamp32(input longint x);
    if (x > longint'(SAT_MAX)) return SAT_MAX;
    if (x < longint'(SAT_MIN)) return SAT_MIN;
    return q16_t'(x);
  endfunction

  // round half up then arithmetic shift (floor)
  function automatic longint round_shr(input longint x, input int sh);
    return (x + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // correction step: err scaled by an unsigned Q16.16 gain, then by the time step
  function automatic q16_t gain_increment(input q16_t err, input logic [DATA_W-1:0] gain,
                                          input dt_t dt);
    q16_t scaled;
    scaled = clamp32(round_shr(longint'(err) * longint'({32'b0, gain}), 16));
    return clamp32(round_shr(longint'(scaled) * longint'({48'b0, dt}), 16));
  endfunction

  // one sample through the third-order filter; updates the in-bench state
  function automatic fusion_res_t fuse_sample(input q16_t baro, input q16_t accel,
                                              input dt_t dt);
    fusion_res_t r;
    int          tap;
    q16_t        err;
    q16_t        prev_accel;
    q16_t        dv;
    q16_t        dp;
    longint      dt64;
    r.height   = '0;
    r.velocity = '0;
    r.accel    = '0;
    r.active   = 1'b0;
    dt64       = longint'({48'b0, dt});
    // counter only moves while below the warm-up length, so lowering the
    // length below the count leaves it where it is and fusion runs
    if (warm_count < warmup_len) warm_count = warm_count + 1'b1;
    if (warm_count < warmup_len) return r;

    // a tap past the end of the history reads the oldest entry
    tap = (int'(tap_sel) >= HIST_DEPTH) ? HIST_DEPTH - 1 : int'(tap_sel);
    err = clamp32(longint'(baro) - longint'(height_hist[tap]));

    acc_corr = clamp32(longint'(acc_corr) + longint'(gain_increment(err, k_acc, dt)));
    vel_corr = clamp32(longint'(vel_corr) + longint'(gain_increment(err, k_vel, dt)));
    pos_corr = clamp32(longint'(pos_corr) + longint'(gain_increment(err, k_pos, dt)));

    // trapezoid integration of the corrected acceleration
    prev_accel = accel_est;
    accel_est  = clamp32(longint'(accel) + longint'(acc_corr));
    dv = clamp32(round_shr((longint'(prev_accel) + longint'(accel_est)) * dt64, 17));
    dp = clamp32(round_shr((2 * longint'(vel_est) + longint'(dv)) * dt64, 17));
    raw_pos  = clamp32(longint'(raw_pos) + longint'(dp));
    r.height = clamp32(longint'(raw_pos) + longint'(pos_corr));
    raw_vel  = clamp32(longint'(raw_vel) + longint'(dv));
    vel_est  = clamp32(longint'(raw_vel) + longint'(vel_corr));

    for (int i = HIST_DEPTH - 1; i > 0; i--) height_hist[i] = height_hist[i - 1];
    height_hist[0] = r.height;

    r.velocity = vel_est;
    r.accel    = accel_est;
    r.active   = 1'b1;
    return r;
  endfunction

  // shadow update on a register write; unknown indexes are dropped
  function automatic void shadow_write(input int idx, input logic [CFG_DW-1:0] v);
    case (idx)
      REG_WARMUP:   warmup_len = v[WARM_W-1:0];
      REG_GAIN_ACC: k_acc      = v;
      REG_GAIN_VEL: k_vel      = v;
      REG_GAIN_POS: k_pos      = v;
      REG_TAP:      tap_sel    = v[TAP_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] shadow_read(input int idx);
    case (idx)
      REG_WARMUP:   return CFG_DW'(warmup_len);
      REG_GAIN_ACC: return k_acc;
      REG_GAIN_VEL: return k_vel;
      REG_GAIN_POS: return k_pos;
      REG_TAP:      return CFG_DW'(tap_sel);
      default:      return '0;
    endcase
  endfunction

  // mostly small realistic gains, sometimes the extremes
  function automatic logic [DATA_W-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom_range(0, 131072);
  endfunction

  function automatic stim_row_t cfg_row(input int idx, input logic [CFG_DW-1:0] v);
    stim_row_t r;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.wdata   = v;
    r.baro    = '0;
    r.accel   = '0;
    r.dt      = '0;
    r.warm    = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t sample_row(input q16_t b, input q16_t a, input dt_t d,
                                           input bit warm);
    stim_row_t r;
    r.kind    = ROW_SAMPLE;
    r.reg_idx = 0;
    r.wdata   = '0;
    r.baro    = b;
    r.accel   = a;
    r.dt      = d;
    r.warm    = warm;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // reporting and bus tasks
  // ---------------------------------------------------------------------------

  // one line per mismatch, printing capped so a broken block cannot flood the log
  task automatic flag_error(input string what, input logic [63:0] got,
                            input logic [63:0] want);
    if (error_count < MAX_PRINTED) begin
      $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
    end
    error_count++;
  endtask

  // apb write: setup phase, then access phase completing on pready
  task automatic reg_write(input int idx, input logic [CFG_DW-1:0] v);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx[CFG_AW-3:0], 2'b00};
    cfg_pwdata  = v;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    shadow_write(idx, v);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic reg_read_check(input int idx);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = {idx[CFG_AW-3:0], 2'b00};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== shadow_read(idx)) begin
      flag_error($sformatf("register %0d readback", idx), cfg_prdata, shadow_read(idx));
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic check_all_regs();
    for (int i = 0; i < NUM_REGS; i++) reg_read_check(i);
  endtask

  // stop sending and wait for every pending result to come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // one input transaction; the expectation is computed at the accepting edge
  task automatic send_sample(input q16_t baro, input q16_t accel, input dt_t dt,
                             input bit warm);
    fusion_res_t want;
    @(negedge clk);
    while (idling && $urandom_range(0, 99) < 24) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.baro_height = baro;
    in_ch.accel_z     = accel;
    in_ch.time_step   = dt;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    want = fuse_sample(baro, accel, dt);
    // table rows marked warm carry the all-zero result typed in
    if (warm) begin
      want.height   = '0;
      want.velocity = '0;
      want.accel    = '0;
      want.active   = 1'b0;
    end
    pending_results.push_back(want);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random backpressure, checking, watchdog
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    out_ch.ready = idling ? ($urandom_range(0, 99) >= 24) : 1'b1;
  end

  // every result transaction is matched against the oldest pending expectation
  always @(posedge clk) begin
    fusion_res_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_error("result with nothing pending", out_ch.fused_height, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.fused_height !== want.height)
          flag_error("fused_height", out_ch.fused_height, want.height);
        if (out_ch.fused_velocity !== want.velocity)
          flag_error("fused_velocity", out_ch.fused_velocity, want.velocity);
        if (out_ch.fused_accel !== want.accel)
          flag_error("fused_accel", out_ch.fused_accel, want.accel);
        if (out_ch.fusion_active !== want.active)
          flag_error("fusion_active", out_ch.fusion_active, want.active);
      end
    end
  end

  // watchdog: too long without any transaction on either channel ends the run
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    stim_row_t         directed [$];
    stim_row_t         row;
    int                n_items;
    int                roll;
    longint            alt_track;
    q16_t              b;
    q16_t              a;
    dt_t               d;

    // every input known from time zero
    rst_n             = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    in_ch.valid       = 1'b0;
    in_ch.baro_height = '0;
    in_ch.accel_z     = '0;
    in_ch.time_step   = '0;
    out_ch.ready      = 1'b0;
    error_count       = 0;
    quiet_cycles      = 0;
    idling            = 1'b1;
    alt_track         = 0;

    // shadow and filter state as after reset
    warmup_len = WARMUP_RST;
    k_acc      = GAIN_ACC_RST;
    k_vel      = GAIN_VEL_RST;
    k_pos      = GAIN_POS_RST;
    tap_sel    = TAP_RST;
    warm_count = '0;
    acc_corr   = '0;
    vel_corr   = '0;
    pos_corr   = '0;
    accel_est  = '0;
    raw_vel    = '0;
    raw_pos    = '0;
    vel_est    = '0;
    for (int i = 0; i < HIST_DEPTH; i++) height_hist[i] = '0;

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // register defaults after reset
    check_all_regs();

    // --- directed table ---
    // short warm-up: two zero results, the third sample fuses
    directed.push_back(cfg_row(REG_WARMUP, 32'd3));
    directed.push_back(sample_row(Q_MAX, Q_MIN, DT_MAX, 1'b1));
    directed.push_back(sample_row(Q_MIN, Q_MAX, '0, 1'b1));
    directed.push_back(sample_row(32'sd6553600, '0, 16'd328, 1'b0));
    // field extremes with reset gains, saturating everything
    directed.push_back(sample_row(Q_MAX, Q_MAX, DT_MAX, 1'b0));
    directed.push_back(sample_row(Q_MIN, Q_MIN, DT_MAX, 1'b0));
    directed.push_back(sample_row('0, '0, '0, 1'b0));
    // warm-up lowered below the count: counter holds and fusion goes on
    directed.push_back(cfg_row(REG_WARMUP, 32'd1));
    directed.push_back(sample_row(32'sd3276800, 32'sd655360, 16'd655, 1'b0));
    // upper bits masked off, warm-up 6: counter climbs through 4 and 5 first
    directed.push_back(cfg_row(REG_WARMUP, 32'hFFFF_FC06));
    directed.push_back(sample_row(32'sd1000, -32'sd1000, 16'd500, 1'b1));
    directed.push_back(sample_row(-32'sd1000, 32'sd1000, 16'd500, 1'b1));
    directed.push_back(sample_row(32'sd6553600, '0, 16'd500, 1'b0));
    // largest gains
    directed.push_back(cfg_row(REG_GAIN_ACC, '1));
    directed.push_back(cfg_row(REG_GAIN_VEL, '1));
    directed.push_back(cfg_row(REG_GAIN_POS, '1));
    directed.push_back(sample_row(Q_MAX, '0, DT_MAX, 1'b0));
    directed.push_back(sample_row(Q_MIN, '0, 16'd1, 1'b0));
    // zero gains, newest history entry
    directed.push_back(cfg_row(REG_GAIN_ACC, '0));
    directed.push_back(cfg_row(REG_GAIN_VEL, '0));
    directed.push_back(cfg_row(REG_GAIN_POS, '0));
    directed.push_back(cfg_row(REG_TAP, '0));
    directed.push_back(sample_row(-32'sd1310720, -32'sd327680, 16'd1000, 1'b0));
    directed.push_back(sample_row(32'sd1310720, 32'sd327680, 16'd1000, 1'b0));
    // oldest history entry, written with all ones so masking is exercised
    directed.push_back(cfg_row(REG_TAP, '1));
    directed.push_back(cfg_row(REG_GAIN_POS, GAIN_POS_RST));
    directed.push_back(sample_row(32'sd655360, '0, 16'd2000, 1'b0));
    directed.push_back(sample_row(-32'sd655360, '0, 16'd2000, 1'b0));
    // writes beyond the register map must change nothing
    directed.push_back(cfg_row(NUM_REGS, '1));
    directed.push_back(cfg_row(LAST_SLOT, '0));
    directed.push_back(sample_row(32'sd100, 32'sd200, 16'd300, 1'b0));
    // no warm-up at all
    directed.push_back(cfg_row(REG_WARMUP, '0));
    directed.push_back(sample_row(-32'sd100, -32'sd200, 16'd300, 1'b0));

    foreach (directed[i]) begin
      row = directed[i];
      if (row.kind == ROW_CFG) begin
        // registers only change with nothing in flight
        drain_results();
        reg_write(row.reg_idx, row.wdata);
        if (row.reg_idx < NUM_REGS) begin
          reg_read_check(row.reg_idx);
        end else begin
          check_all_regs();
        end
      end else begin
        send_sample(row.baro, row.accel, row.dt, row.warm);
      end
    end

    // --- random phases ---
    // each phase reprograms every register; phase 2 runs with no idling on
    // either side, the last phase uses the longest warm-up
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      idling = (ph != 2);
      if (ph == 0) begin
        reg_write(REG_WARMUP, $urandom_range(0, 15));
        reg_write(REG_GAIN_ACC, GAIN_ACC_RST);
        reg_write(REG_GAIN_VEL, GAIN_VEL_RST);
        reg_write(REG_GAIN_POS, GAIN_POS_RST);
        reg_write(REG_TAP, TAP_RST);
      end else begin
        reg_write(REG_WARMUP, (ph == NUM_PHASES - 1) ? 32'd1023 : $urandom_range(0, 20));
        reg_write(REG_GAIN_ACC, pick_gain());
        reg_write(REG_GAIN_VEL, pick_gain());
        reg_write(REG_GAIN_POS, pick_gain());
        reg_write(REG_TAP, $urandom_range(0, 7));
      end
      check_all_regs();

      // the last phase adds its full warm-up length on top of the phase length
      n_items = PHASE_ITEMS + ((ph == NUM_PHASES - 1) ? 1023 : 0);
      for (int k = 0; k < n_items; k++) begin
        // now and then hold off until the block has handed back everything
        if ($urandom_range(0, 99) == 0) drain_results();
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          // full-range noise: every bit of every field toggles
          b = $urandom;
          a = $urandom;
          d = $urandom_range(0, 65535);
        end else begin
          // well-formed flight: slow altitude walk, barometer noise, small accel
          alt_track = alt_track + longint'($urandom_range(0, 2 << 20)) - (longint'(1) << 20);
          if (alt_track > (longint'(1) << 28)) alt_track = longint'(1) << 28;
          if (alt_track < -(longint'(1) << 28)) alt_track = -(longint'(1) << 28);
          b = q16_t'(alt_track + longint'($urandom_range(0, 1 << 19)) - (longint'(1) << 18));
          a = q16_t'(longint'($urandom_range(0, 1 << 23)) - (longint'(1) << 22));
          d = (roll < 10) ? dt_t'(0) : dt_t'($urandom_range(100, 1500));
        end
        send_sample(b, a, d, 1'b0);
      end
    end

    // --- wind down ---
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_error("results never delivered", pending_results.size(), '0);
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[vertical_complementary_fusion.f]
sv/vcf_pkg.sv
sv/vcf_if.sv
sv/vcf_useq.sv
sv/vertical_complementary_fusion.sv
tb/tb_vertical_complementary_fusion.sv
